// ===== hdl/hrbp_pkg.sv =====
// Package with the constants, types and verb table of the HTTP request byte parser.
`default_nettype none

package hrbp_pkg;

   localparam int METHOD_MAX_LEN = 7;
   localparam int CHAR_IDX_W     = $clog2(METHOD_MAX_LEN);
   localparam int METHOD_LEN_W   = $clog2(METHOD_MAX_LEN + 2);
   localparam int VERB_COUNT     = 8;
   localparam int VERB_MAX_CHARS = 7;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [2:0] CLASS_NONE    = 3'd0;
   localparam logic [2:0] CLASS_METHOD  = 3'd1;
   localparam logic [2:0] CLASS_TARGET  = 3'd2;
   localparam logic [2:0] CLASS_VERSION = 3'd3;
   localparam logic [2:0] CLASS_HDR_NAME  = 3'd4;
   localparam logic [2:0] CLASS_HDR_VALUE = 3'd5;
   localparam logic [2:0] CLASS_BODY    = 3'd6;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_BAD_METHOD  = 2'd1;
   localparam logic [1:0] ERR_LONE_CR     = 2'd2;
   localparam logic [1:0] ERR_EARLY_END   = 2'd3;

   localparam logic [3:0] METHOD_UNKNOWN = 4'd0;

   typedef enum logic [4:0] {
      PHASE_METHOD  = 5'b00001,
      PHASE_TARGET  = 5'b00010,
      PHASE_VERSION = 5'b00100,
      PHASE_HEADERS = 5'b01000,
      PHASE_BODY    = 5'b10000
   } phase_type;

   typedef logic [7:0] method_buf_type [METHOD_MAX_LEN];

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] field_class;
      logic [3:0] method_code;
      logic       header_line_end;
      logic       header_has_colon;
      logic       body_start;
      logic [1:0] error_code;
      logic       last_out;
   } result_type;

   localparam int VERB_LEN [VERB_COUNT] = '{3, 4, 3, 6, 4, 7, 5, 7};

   localparam logic [7:0] VERB_TEXT [VERB_COUNT][VERB_MAX_CHARS] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T"},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S"}
   };

   // Returns the code of the verb held in the buffer, or zero when none matches.
   function automatic logic [3:0] match_method(
      input method_buf_type              chars,
      input logic [METHOD_LEN_W-1:0]     len
   );
      logic [3:0] code;
      logic       hit;
      code = METHOD_UNKNOWN;
      for (int v = VERB_COUNT - 1; v >= 0; v--) begin
         hit = (int'(len) == VERB_LEN[v]) && (int'(len) <= METHOD_MAX_LEN);
         for (int j = 0; j < VERB_MAX_CHARS; j++) begin
            if (j < VERB_LEN[v] && chars[j] != VERB_TEXT[v][j]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = 4'(v + 1);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/http_request_byte_parser_unit.sv =====
// Top level of the HTTP request byte parser: byte classification, state and output skid stage.
// The result for a byte is registered in the output register, or in the skid entry while that register is held.
// Throughput: one byte per cycle while req_stall is low, as the phase update and verb compare are combinational.
// The skid entry takes one further input transfer while a result waits; req_stall then stays high until it drains.
// Reset is synchronous and active high; it returns the parser to the method phase
// and empties the output stage. The parser also returns to that state after each last byte.
`default_nettype none

module http_request_byte_parser_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte_out,
   output logic [2:0]      rsp_field_class,
   output logic [3:0]      rsp_method_code,
   output logic            rsp_header_line_end,
   output logic            rsp_header_has_colon,
   output logic            rsp_body_start,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last_out
);
   import hrbp_pkg::*;

   phase_type                 phase_ff, phase_in;
   method_buf_type            method_chars_ff;
   logic [METHOD_LEN_W-1:0]   method_length_ff, method_length_in;
   logic                      pending_cr_ff, pending_cr_in;
   logic                      line_nonempty_ff, line_nonempty_in;
   logic                      colon_seen_ff, colon_seen_in;
   logic                      skip_next_ff, skip_next_in;
   logic                      stopped_ff, stopped_in;
   logic                      char_write;

   result_type                result;
   result_type                out_ff, out_in;
   result_type                skid_ff, skid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;

   logic                      accept;
   logic                      out_take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      phase_in         = phase_ff;
      method_length_in = method_length_ff;
      pending_cr_in    = pending_cr_ff;
      line_nonempty_in = line_nonempty_ff;
      colon_seen_in    = colon_seen_ff;
      skip_next_in     = skip_next_ff;
      stopped_in       = stopped_ff;
      char_write       = 1'b0;

      result                  = '0;
      result.byte_out         = req_data_byte;
      result.field_class      = CLASS_NONE;
      result.method_code      = METHOD_UNKNOWN;
      result.error_code       = ERR_NONE;
      result.last_out         = req_last_byte;

      if (!stopped_ff) begin
         case (phase_ff)
            PHASE_METHOD: begin
               if (req_data_byte != CHAR_SPACE) begin
                  result.field_class = CLASS_METHOD;
                  if (int'(method_length_ff) < METHOD_MAX_LEN) begin
                     char_write = 1'b1;
                  end
                  if (int'(method_length_ff) <= METHOD_MAX_LEN) begin
                     method_length_in = method_length_ff + 1'b1;
                  end
               end else begin
                  result.method_code = match_method(method_chars_ff, method_length_ff);
                  if (result.method_code != METHOD_UNKNOWN) begin
                     phase_in = PHASE_TARGET;
                  end else begin
                     result.error_code = ERR_BAD_METHOD;
                     stopped_in        = 1'b1;
                  end
               end
            end
            PHASE_TARGET: begin
               if (req_data_byte != CHAR_SPACE) begin
                  result.field_class = CLASS_TARGET;
               end else begin
                  phase_in = PHASE_VERSION;
               end
            end
            PHASE_VERSION: begin
               if (pending_cr_ff) begin
                  pending_cr_in = 1'b0;
                  if (req_data_byte == CHAR_LF) begin
                     phase_in = PHASE_HEADERS;
                  end else begin
                     result.error_code = ERR_LONE_CR;
                     stopped_in        = 1'b1;
                  end
               end else if (req_data_byte == CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  result.field_class = CLASS_VERSION;
               end
            end
            PHASE_HEADERS: begin
               if (pending_cr_ff) begin
                  pending_cr_in = 1'b0;
                  if (req_data_byte != CHAR_LF) begin
                     result.error_code = ERR_LONE_CR;
                     stopped_in        = 1'b1;
                  end else if (line_nonempty_ff) begin
                     result.header_line_end  = 1'b1;
                     result.header_has_colon = colon_seen_ff;
                     line_nonempty_in        = 1'b0;
                     colon_seen_in           = 1'b0;
                     skip_next_in            = 1'b0;
                  end else begin
                     result.body_start = 1'b1;
                     phase_in          = PHASE_BODY;
                  end
               end else if (req_data_byte == CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  line_nonempty_in = 1'b1;
                  if (!colon_seen_ff) begin
                     if (req_data_byte == CHAR_COLON) begin
                        colon_seen_in = 1'b1;
                        skip_next_in  = 1'b1;
                     end else begin
                        result.field_class = CLASS_HDR_NAME;
                     end
                  end else if (skip_next_ff) begin
                     skip_next_in = 1'b0;
                  end else begin
                     result.field_class = CLASS_HDR_VALUE;
                  end
               end
            end
            PHASE_BODY: begin
               result.field_class = CLASS_BODY;
            end
            default: begin
               phase_in = PHASE_METHOD;
            end
         endcase
         if (req_last_byte && !stopped_in) begin
            if (pending_cr_in) begin
               result.error_code = ERR_LONE_CR;
            end else if (phase_in != PHASE_BODY) begin
               result.error_code = ERR_EARLY_END;
            end
         end
      end

      // The last byte of a request returns the parser to its idle state.
      if (req_last_byte) begin
         phase_in         = PHASE_METHOD;
         method_length_in = '0;
         pending_cr_in    = 1'b0;
         line_nonempty_in = 1'b0;
         colon_seen_in    = 1'b0;
         skip_next_in     = 1'b0;
         stopped_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_METHOD;
         method_length_ff <= '0;
         pending_cr_ff    <= 1'b0;
         line_nonempty_ff <= 1'b0;
         colon_seen_ff    <= 1'b0;
         skip_next_ff     <= 1'b0;
         stopped_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         method_length_ff <= method_length_in;
         pending_cr_ff    <= pending_cr_in;
         line_nonempty_ff <= line_nonempty_in;
         colon_seen_ff    <= colon_seen_in;
         skip_next_ff     <= skip_next_in;
         stopped_ff       <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && char_write) begin
         method_chars_ff[method_length_ff[CHAR_IDX_W-1:0]] <= req_data_byte;
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_byte_out         = out_ff.byte_out;
   assign rsp_field_class      = out_ff.field_class;
   assign rsp_method_code      = out_ff.method_code;
   assign rsp_header_line_end  = out_ff.header_line_end;
   assign rsp_header_has_colon = out_ff.header_has_colon;
   assign rsp_body_start       = out_ff.body_start;
   assign rsp_error_code       = out_ff.error_code;
   assign rsp_last_out         = out_ff.last_out;

endmodule

`default_nettype wire
